[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl of the disc pair collision block
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define DPEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define DPEC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/dpec_pkg.sv]
// types and constants shared by the disc pair collision rtl
// no dependencies
`default_nettype none

package dpec_pkg;

  localparam int Q_W        = 19;
  localparam int NUM_W      = 62;
  localparam int DEN_W      = 43;
  localparam int PH_W       = 22;
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    ST_APART      = 2'd0,
    ST_SEPARATING = 2'd1,
    ST_IMPULSE    = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [15:0] v1x;
    logic signed [15:0] v1y;
    logic signed [15:0] v2x;
    logic signed [15:0] v2y;
    logic [15:0]        m1;
    logic [15:0]        m2;
    logic signed [13:0] dx;
    logic signed [13:0] dy;
    logic [24:0]        dist2;
    logic signed [31:0] dot;
    status_t            status;
  } item_t;

  typedef struct packed {
    logic signed [15:0] v1x;
    logic signed [15:0] v1y;
    logic signed [15:0] v2x;
    logic signed [15:0] v2y;
    status_t            status;
    logic               neg_x;
    logic               neg_y;
  } side_t;

endpackage

`default_nettype wire

[hw/rtl/dpec_front.sv]
// front end: takes a disc pair request, works out separation and closing speed, classifies it
// depends on dpec_pkg
`default_nettype none

module dpec_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         in_first_pos_x,
  input  logic [15:0]         in_first_pos_y,
  input  logic signed [15:0]  in_first_vel_x,
  input  logic signed [15:0]  in_first_vel_y,
  input  logic [11:0]         in_first_diameter,
  input  logic [15:0]         in_first_mass,
  input  logic [15:0]         in_second_pos_x,
  input  logic [15:0]         in_second_pos_y,
  input  logic signed [15:0]  in_second_vel_x,
  input  logic signed [15:0]  in_second_vel_y,
  input  logic [11:0]         in_second_diameter,
  input  logic [15:0]         in_second_mass,
  output logic                q_push,
  output dpec_pkg::item_t     q_item,
  input  logic                q_full
);
  import dpec_pkg::*;

  logic en;

  logic               f1_vld_r, f2_vld_r, f3_vld_r;
  logic signed [16:0] f1_dx_r, f1_dy_r, f1_dvx_r, f1_dvy_r;
  logic [12:0]        f1_dsum_r;
  logic signed [15:0] f1_v1x_r, f1_v1y_r, f1_v2x_r, f1_v2y_r;
  logic [15:0]        f1_m1_r, f1_m2_r;

  logic signed [33:0] f2_dxx_r, f2_dyy_r, f2_pdx_r, f2_pdy_r;
  logic [25:0]        f2_ds2_r;
  logic signed [16:0] f2_dx_r, f2_dy_r;
  logic signed [15:0] f2_v1x_r, f2_v1y_r, f2_v2x_r, f2_v2y_r;
  logic [15:0]        f2_m1_r, f2_m2_r;

  logic [34:0]        dist2_w;
  logic signed [34:0] dot_w;
  logic               hit;
  item_t              item_nxt;
  item_t              f3_item_r;

  assign en       = !(f3_vld_r && q_full);
  assign in_ready = en;
  assign q_push   = f3_vld_r && !q_full;
  assign q_item   = f3_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      f3_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= in_valid;
      f2_vld_r <= f1_vld_r;
      f3_vld_r <= f2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_dx_r   <= $signed({1'b0, in_second_pos_x}) - $signed({1'b0, in_first_pos_x});
      f1_dy_r   <= $signed({1'b0, in_second_pos_y}) - $signed({1'b0, in_first_pos_y});
      f1_dvx_r  <= $signed({in_second_vel_x[15], in_second_vel_x})
                 - $signed({in_first_vel_x[15], in_first_vel_x});
      f1_dvy_r  <= $signed({in_second_vel_y[15], in_second_vel_y})
                 - $signed({in_first_vel_y[15], in_first_vel_y});
      f1_dsum_r <= 13'(in_first_diameter) + 13'(in_second_diameter);
      f1_v1x_r  <= in_first_vel_x;
      f1_v1y_r  <= in_first_vel_y;
      f1_v2x_r  <= in_second_vel_x;
      f1_v2y_r  <= in_second_vel_y;
      f1_m1_r   <= in_first_mass;
      f1_m2_r   <= in_second_mass;

      f2_dxx_r <= f1_dx_r * f1_dx_r;
      f2_dyy_r <= f1_dy_r * f1_dy_r;
      f2_pdx_r <= f1_dvx_r * f1_dx_r;
      f2_pdy_r <= f1_dvy_r * f1_dy_r;
      f2_ds2_r <= f1_dsum_r * f1_dsum_r;
      f2_dx_r  <= f1_dx_r;
      f2_dy_r  <= f1_dy_r;
      f2_v1x_r <= f1_v1x_r;
      f2_v1y_r <= f1_v1y_r;
      f2_v2x_r <= f1_v2x_r;
      f2_v2y_r <= f1_v2y_r;
      f2_m1_r  <= f1_m1_r;
      f2_m2_r  <= f1_m2_r;

      f3_item_r <= item_nxt;
    end
  end

  always_comb begin
    dist2_w = 35'($unsigned(f2_dxx_r)) + 35'($unsigned(f2_dyy_r));
    dot_w   = 35'(f2_pdx_r) + 35'(f2_pdy_r);
    hit     = (dist2_w != '0) && ({dist2_w, 2'b00} <= 37'(f2_ds2_r));

    item_nxt.v1x   = f2_v1x_r;
    item_nxt.v1y   = f2_v1y_r;
    item_nxt.v2x   = f2_v2x_r;
    item_nxt.v2y   = f2_v2y_r;
    item_nxt.m1    = f2_m1_r;
    item_nxt.m2    = f2_m2_r;
    item_nxt.dx    = f2_dx_r[13:0];
    item_nxt.dy    = f2_dy_r[13:0];
    item_nxt.dist2 = dist2_w[24:0];
    item_nxt.dot   = dot_w[31:0];
    // both masses zero behave as two unit masses
    if ((f2_m1_r == '0) && (f2_m2_r == '0)) begin
      item_nxt.m1 = 16'd1;
      item_nxt.m2 = 16'd1;
    end
    if (!hit) begin
      item_nxt.status = ST_APART;
    end else if (!dot_w[34]) begin
      item_nxt.status = ST_SEPARATING;
    end else begin
      item_nxt.status = ST_IMPULSE;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dpec_fifo.sv]
// short request queue between the classifying front end and the impulse back end
// depends on dpec_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module dpec_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dpec_pkg::item_t wdata,
  input  logic            pop,
  output dpec_pkg::item_t rdata,
  output logic            full,
  output logic            empty
);
  import dpec_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  item_t         mem_r [FIFO_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `DPEC_ASSERT_NEVER(a_no_overflow, push && full && !pop, "request pushed into full queue")
  `DPEC_ASSERT_NEVER(a_no_underflow, pop && empty, "request popped from empty queue")
  `DPEC_ASSERT(a_count_up, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1), "count lost a push")

endmodule

`default_nettype wire

[hw/rtl/dpec_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on dpec_pkg
`default_nettype none

module dpec_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [dpec_pkg::NUM_W-1:0] num,
  input  logic [dpec_pkg::DEN_W-1:0] dvs,
  output logic [dpec_pkg::Q_W-1:0]   quo
);
  import dpec_pkg::*;

  logic [NUM_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] dvs_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int B = Q_W - 1 - s;
    logic [NUM_W-1:0] src_rem;
    logic [DEN_W-1:0] src_dvs;
    logic [Q_W-1:0]   src_q;
    logic [NUM_W:0]   sh, diff;
    logic             take;

    if (s == 0) begin : g_first
      assign src_rem = num;
      assign src_dvs = dvs;
      assign src_q   = '0;
    end else begin : g_next
      assign src_rem = rem_r[s-1];
      assign src_dvs = dvs_r[s-1];
      assign src_q   = q_r[s-1];
    end

    always_comb begin
      sh   = (NUM_W+1)'(src_dvs) << B;
      diff = {1'b0, src_rem} - sh;
      take = !diff[NUM_W];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= take ? diff[NUM_W-1:0] : src_rem;
        dvs_r[s] <= src_dvs;
        q_r[s]   <= src_q | (Q_W'(take) << B);
      end
    end
  end

  assign quo = q_r[Q_W-1];

endmodule

`default_nettype wire

[hw/rtl/dpec_back.sv]
// back end: impulse products, four pipelined dividers, rounding and saturation, output register
// depends on dpec_pkg and dpec_div
`default_nettype none

module dpec_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dpec_pkg::item_t     q_item,
  input  logic                q_valid,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_new_first_vel_x,
  output logic signed [15:0]  out_new_first_vel_y,
  output logic signed [15:0]  out_new_second_vel_x,
  output logic signed [15:0]  out_new_second_vel_y,
  output logic [1:0]          out_contact_status
);
  import dpec_pkg::*;

  function automatic logic signed [15:0] sat_add(logic signed [15:0] v, logic [Q_W-1:0] q,
                                                 logic neg);
    logic signed [Q_W:0]   d;
    logic signed [Q_W+1:0] s;
    d = $signed({1'b0, q});
    if (neg) begin
      d = -d;
    end
    s = (Q_W+2)'(v) + (Q_W+2)'(d);
    if (s > (Q_W+2)'(32767)) begin
      return 16'sh7fff;
    end else if (s < -(Q_W+2)'(32768)) begin
      return -16'sh8000;
    end
    return s[15:0];
  endfunction

  logic en;

  logic        b1_vld_r, b2_vld_r, b3_vld_r, out_vld_r;
  logic        sv_r [Q_W];
  side_t       sd_r [Q_W];

  logic [30:0] ad;
  logic [12:0] acx, acy;
  side_t       side_nxt;

  side_t       b1_side_r, b2_side_r, b3_side_r;
  logic [41:0] b1_den_r, b2_den_r;
  logic [43:0] b1_pax_r, b1_pay_r;
  logic [15:0] b1_m1_r, b1_m2_r;
  logic [37:0] b2_lo_r [4];
  logic [37:0] b2_hi_r [4];
  logic [NUM_W-1:0] b3_num_r [4];
  logic [DEN_W-1:0] b3_dvs_r;
  logic [Q_W-1:0]   quo [4];

  logic signed [15:0] r1x, r1y, r2x, r2y;
  side_t              last;

  assign en        = !out_vld_r || out_ready;
  assign q_pop     = en && q_valid;
  assign out_valid = out_vld_r;

  always_comb begin
    ad  = q_item.dot[31] ? 31'(-q_item.dot) : 31'(q_item.dot);
    acx = q_item.dx[13] ? 13'(-q_item.dx) : 13'(q_item.dx);
    acy = q_item.dy[13] ? 13'(-q_item.dy) : 13'(q_item.dy);
    side_nxt.v1x    = q_item.v1x;
    side_nxt.v1y    = q_item.v1y;
    side_nxt.v2x    = q_item.v2x;
    side_nxt.v2y    = q_item.v2y;
    side_nxt.status = q_item.status;
    side_nxt.neg_x  = q_item.dot[31] ^ q_item.dx[13];
    side_nxt.neg_y  = q_item.dot[31] ^ q_item.dy[13];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r  <= 1'b0;
      b2_vld_r  <= 1'b0;
      b3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      for (int s = 0; s < Q_W; s++) begin
        sv_r[s] <= 1'b0;
      end
    end else if (en) begin
      b1_vld_r <= q_valid;
      b2_vld_r <= b1_vld_r;
      b3_vld_r <= b2_vld_r;
      sv_r[0]  <= b3_vld_r;
      for (int s = 1; s < Q_W; s++) begin
        sv_r[s] <= sv_r[s-1];
      end
      out_vld_r <= sv_r[Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_side_r <= side_nxt;
      b1_den_r  <= (17'(q_item.m1) + 17'(q_item.m2)) * q_item.dist2;
      b1_pax_r  <= ad * acx;
      b1_pay_r  <= ad * acy;
      b1_m1_r   <= q_item.m1;
      b1_m2_r   <= q_item.m2;

      // first disc is weighted by the second mass and vice versa
      b2_side_r  <= b1_side_r;
      b2_den_r   <= b1_den_r;
      b2_lo_r[0] <= b1_m2_r * b1_pax_r[PH_W-1:0];
      b2_hi_r[0] <= b1_m2_r * b1_pax_r[43:PH_W];
      b2_lo_r[1] <= b1_m2_r * b1_pay_r[PH_W-1:0];
      b2_hi_r[1] <= b1_m2_r * b1_pay_r[43:PH_W];
      b2_lo_r[2] <= b1_m1_r * b1_pax_r[PH_W-1:0];
      b2_hi_r[2] <= b1_m1_r * b1_pax_r[43:PH_W];
      b2_lo_r[3] <= b1_m1_r * b1_pay_r[PH_W-1:0];
      b2_hi_r[3] <= b1_m1_r * b1_pay_r[43:PH_W];

      // numerator 4*w*|dot|*|comp| + den, divisor 2*den, for round half away from zero
      b3_side_r <= b2_side_r;
      b3_dvs_r  <= {b2_den_r, 1'b0};
      for (int k = 0; k < 4; k++) begin
        b3_num_r[k] <= {b2_hi_r[k], 24'b0} + NUM_W'({b2_lo_r[k], 2'b00}) + NUM_W'(b2_den_r);
      end

      sd_r[0] <= b3_side_r;
      for (int s = 1; s < Q_W; s++) begin
        sd_r[s] <= sd_r[s-1];
      end

      out_new_first_vel_x  <= r1x;
      out_new_first_vel_y  <= r1y;
      out_new_second_vel_x <= r2x;
      out_new_second_vel_y <= r2y;
      out_contact_status   <= 2'(last.status);
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_div
    dpec_div u_div (
      .clk (clk),
      .en  (en),
      .num (b3_num_r[k]),
      .dvs (b3_dvs_r),
      .quo (quo[k])
    );
  end

  always_comb begin
    last = sd_r[Q_W-1];
    r1x  = last.v1x;
    r1y  = last.v1y;
    r2x  = last.v2x;
    r2y  = last.v2y;
    if (last.status == ST_IMPULSE) begin
      r1x = sat_add(last.v1x, quo[0], last.neg_x);
      r1y = sat_add(last.v1y, quo[1], last.neg_y);
      r2x = sat_add(last.v2x, quo[2], !last.neg_x);
      r2y = sat_add(last.v2y, quo[3], !last.neg_y);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/disc_pair_elastic_collision.sv]
// Elastic collision response for a pair of discs. Takes one pair request per clock while
// in_ready is high and returns one result per request, in order, through three front
// stages (separation, squares and closing speed, classification), the request queue,
// three back stages (denominator and products, mass weighting, numerator), the 19-stage
// restoring divider that sets the latency, and the output register. Sustained rate is
// one pair per cycle while out_ready holds high. Status 0 means apart or coincident
// centres, 1 overlapping but separating, 2 impulse applied; velocities saturate to the
// 16-bit range.
// depends on dpec_pkg, dpec_front, dpec_fifo, dpec_back
`default_nettype none

module disc_pair_elastic_collision (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_first_pos_x,
  input  logic [15:0]        in_first_pos_y,
  input  logic signed [15:0] in_first_vel_x,
  input  logic signed [15:0] in_first_vel_y,
  input  logic [11:0]        in_first_diameter,
  input  logic [15:0]        in_first_mass,
  input  logic [15:0]        in_second_pos_x,
  input  logic [15:0]        in_second_pos_y,
  input  logic signed [15:0] in_second_vel_x,
  input  logic signed [15:0] in_second_vel_y,
  input  logic [11:0]        in_second_diameter,
  input  logic [15:0]        in_second_mass,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_new_first_vel_x,
  output logic signed [15:0] out_new_first_vel_y,
  output logic signed [15:0] out_new_second_vel_x,
  output logic signed [15:0] out_new_second_vel_y,
  output logic [1:0]         out_contact_status
);
  import dpec_pkg::*;

  logic  q_push, q_pop, q_full, q_empty;
  item_t q_wdata, q_rdata;

  dpec_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_first_pos_x     (in_first_pos_x),
    .in_first_pos_y     (in_first_pos_y),
    .in_first_vel_x     (in_first_vel_x),
    .in_first_vel_y     (in_first_vel_y),
    .in_first_diameter  (in_first_diameter),
    .in_first_mass      (in_first_mass),
    .in_second_pos_x    (in_second_pos_x),
    .in_second_pos_y    (in_second_pos_y),
    .in_second_vel_x    (in_second_vel_x),
    .in_second_vel_y    (in_second_vel_y),
    .in_second_diameter (in_second_diameter),
    .in_second_mass     (in_second_mass),
    .q_push             (q_push),
    .q_item             (q_wdata),
    .q_full             (q_full)
  );

  dpec_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  dpec_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_item               (q_rdata),
    .q_valid              (!q_empty),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_new_first_vel_x  (out_new_first_vel_x),
    .out_new_first_vel_y  (out_new_first_vel_y),
    .out_new_second_vel_x (out_new_second_vel_x),
    .out_new_second_vel_y (out_new_second_vel_y),
    .out_contact_status   (out_contact_status)
  );

endmodule

`default_nettype wire
